FILE: design/bcus_pkg.sv
`default_nettype none

package bcus_pkg;

  // Field widths.
  localparam int COUNT_W     = 63;
  localparam int STEP_W      = 4;
  localparam int VAL_W       = 25;
  localparam int FRAC_W      = 7;
  localparam int FW_W        = 2;
  localparam int UNIT_W      = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STEP_W + VAL_W + VAL_W + FRAC_W + FW_W + UNIT_W);

  // Divider datapath: 64-bit dividend, divisor up to ten to the twelfth,
  // and a quotient that always fits in the scaled value field.
  localparam int NUM_W = 64;
  localparam int DEN_W = 41;
  localparam int QUO_W = VAL_W;
  localparam int CNT_W = $clog2(QUO_W);

  localparam int MAX_STEPS   = 12;
  localparam int RAW_LIMIT   = 1000;
  localparam int TRIAL_LIMIT = 1999;
  localparam int FIRST_HALF  = 5;
  localparam int DEC_BASE    = 10;
  localparam int UNIT_MAX    = 3;

  // Fraction width codes.
  localparam logic [FW_W-1:0] FW_NONE = 2'd0;
  localparam logic [FW_W-1:0] FW_ONE  = 2'd1;
  localparam logic [FW_W-1:0] FW_TWO  = 2'd2;

  localparam logic [DEN_W-1:0] SPLIT_ONE_DEN = DEN_W'(10);
  localparam logic [DEN_W-1:0] SPLIT_TWO_DEN = DEN_W'(100);

  typedef logic [NUM_W-1:0]  wide_tab_t [MAX_STEPS+1];
  typedef logic [DEN_W-1:0]  den_tab_t  [MAX_STEPS+1];
  typedef logic [FW_W-1:0]   fw_tab_t   [MAX_STEPS+1];
  typedef logic [UNIT_W-1:0] unit_tab_t [MAX_STEPS+1];

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
    logic [DEN_W-1:0]  rem;
  } div_rsp_t;

  // Step k qualifies when count is below 1999 * 5 * 10^(k-1).
  function automatic wide_tab_t build_limit_tab();
    wide_tab_t        t;
    logic [NUM_W-1:0] p;
    p    = NUM_W'(1);
    t[0] = '0;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      t[k] = NUM_W'(TRIAL_LIMIT) * NUM_W'(FIRST_HALF) * p;
      p    = p * NUM_W'(DEC_BASE);
    end
    return t;
  endfunction

  // Half of the step divisor: 5 * 10^(k-1).
  function automatic den_tab_t build_half_tab();
    den_tab_t         t;
    logic [DEN_W-1:0] p;
    p    = DEN_W'(1);
    t[0] = '0;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      t[k] = DEN_W'(FIRST_HALF) * p;
      p    = p * DEN_W'(DEC_BASE);
    end
    return t;
  endfunction

  // Full step divisor: 10^k.
  function automatic den_tab_t build_pow_tab();
    den_tab_t         t;
    logic [DEN_W-1:0] p;
    p    = DEN_W'(1);
    t[0] = p;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      p    = p * DEN_W'(DEC_BASE);
      t[k] = p;
    end
    return t;
  endfunction

  function automatic fw_tab_t build_fw_tab();
    fw_tab_t t;
    t[0] = FW_NONE;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      if (k % 3 == 1) begin
        t[k] = FW_TWO;
      end else if (k % 3 == 2) begin
        t[k] = FW_ONE;
      end else begin
        t[k] = FW_NONE;
      end
    end
    return t;
  endfunction

  function automatic unit_tab_t build_unit_tab();
    unit_tab_t t;
    t[0] = '0;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      if ((k - 1) / 3 > UNIT_MAX) begin
        t[k] = UNIT_W'(UNIT_MAX);
      end else begin
        t[k] = UNIT_W'((k - 1) / 3);
      end
    end
    return t;
  endfunction

  localparam wide_tab_t LIMIT_TAB = build_limit_tab();
  localparam den_tab_t  HALF_TAB  = build_half_tab();
  localparam den_tab_t  POW_TAB   = build_pow_tab();
  localparam fw_tab_t   FW_TAB    = build_fw_tab();
  localparam unit_tab_t UNIT_TAB  = build_unit_tab();

endpackage

`default_nettype wire

FILE: design/bcus_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The upper dividend bits
// are preloaded into the remainder, which is valid because every quotient
// this block asks for fits in QUO_W bits.
module bcus_divider import bcus_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[QUO_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        den_r  <= req.den;
        rem_r  <= DEN_W'(req.num[NUM_W-1:QUO_W]);
        quo_r  <= req.num[QUO_W-1:0];
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[QUO_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: design/byte_count_unit_scaler_core.sv
`default_nettype none

// Channel  Handshake                  Payload
// -------  -------------------------  ------------------------------------------------
// in       in_tvalid / in_tready      in_tdata: byte_count
// out      out_tvalid / out_tready    out_tuser: raw_flag; out_tdata: decimal_step ..
//
// A count below 1000 goes from the idle state straight to the finish state,
// which loads the output register and raises out_tvalid once it is free.
// Any other count goes through the threshold search one step per cycle, then
// through one pass of the shared serial divider for the rounding and, when a
// fraction is shown, a second pass for the digit split, and last through the
// finish state, which loads the output register when it is free.
// Reset is synchronous and active low; it empties the sequencer and the output.
// in_tready is high only while the sequencer is idle. A finished result waits
// in the output register; the next item may be taken meanwhile, and the
// sequencer stalls in its final state until the output register is free.
module byte_count_unit_scaler_core import bcus_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [62:0] byte_count, [63] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,

  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] decimal_step, [28:4] scaled_value, [53:29] integer_digits,
  // [60:54] fraction_digits, [62:61] fraction_width, [64:63] unit_code,
  // [71:65] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] raw_flag
  output logic                   out_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ROUND,
    ST_SPLIT,
    ST_FINISH
  } state_t;

  state_t              state_r,    state_nxt;
  logic [COUNT_W-1:0]  count_r,    count_nxt;
  logic [STEP_W-1:0]   k_r,        k_nxt;
  logic                raw_r,      raw_nxt;
  logic [VAL_W-1:0]    trial_r,    trial_nxt;
  logic [VAL_W-1:0]    int_r,      int_nxt;
  logic [FRAC_W-1:0]   frac_r,     frac_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_raw_r,   out_raw_nxt;
  logic [STEP_W-1:0]   out_step_r,  out_step_nxt;
  logic [VAL_W-1:0]    out_val_r,   out_val_nxt;
  logic [VAL_W-1:0]    out_int_r,   out_int_nxt;
  logic [FRAC_W-1:0]   out_frac_r,  out_frac_nxt;
  logic [FW_W-1:0]     out_fw_r,    out_fw_nxt;
  logic [UNIT_W-1:0]   out_unit_r,  out_unit_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [COUNT_W-1:0]  in_count;

  assign in_count = in_tdata[COUNT_W-1:0];

  // A serial divider, shared by the rounding
  // division and the digit split.
  bcus_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    raw_nxt       = raw_r;
    trial_nxt     = trial_r;
    int_nxt       = int_r;
    frac_nxt      = frac_r;
    out_valid_nxt = out_valid_r;
    out_raw_nxt   = out_raw_r;
    out_step_nxt  = out_step_r;
    out_val_nxt   = out_val_r;
    out_int_nxt   = out_int_r;
    out_frac_nxt  = out_frac_r;
    out_fw_nxt    = out_fw_r;
    out_unit_nxt  = out_unit_r;
    div_req       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          count_nxt = in_count;
          if (in_count < COUNT_W'(RAW_LIMIT)) begin
            // Small counts pass through unscaled; step zero selects
            // the empty entries of the unit and fraction tables.
            raw_nxt   = 1'b1;
            k_nxt     = '0;
            trial_nxt = in_count[VAL_W-1:0];
            int_nxt   = in_count[VAL_W-1:0];
            frac_nxt  = '0;
            state_nxt = ST_FINISH;
          end else begin
            raw_nxt   = 1'b0;
            k_nxt     = STEP_W'(1);
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        // count / (5 * 10^(k-1)) < 1999 is the same test as a compare of
        // the count against a precomputed threshold.
        if ({1'b0, count_r} < LIMIT_TAB[k_r]) begin
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(count_r) + NUM_W'(HALF_TAB[k_r]);
          div_req.den   = POW_TAB[k_r];
          state_nxt     = ST_ROUND;
        end else if (k_r == STEP_W'(MAX_STEPS)) begin
          // No step qualified: keep the unrounded quotient of the count by the half step divisor.
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(count_r);
          div_req.den   = HALF_TAB[k_r];
          state_nxt     = ST_ROUND;
        end else begin
          k_nxt = k_r + STEP_W'(1);
        end
      end

      ST_ROUND: begin
        if (div_rsp.done) begin
          trial_nxt = div_rsp.quo;
          if (FW_TAB[k_r] == FW_NONE) begin
            int_nxt   = div_rsp.quo;
            frac_nxt  = '0;
            state_nxt = ST_FINISH;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(div_rsp.quo);
            div_req.den   = (FW_TAB[k_r] == FW_TWO) ? SPLIT_TWO_DEN : SPLIT_ONE_DEN;
            state_nxt     = ST_SPLIT;
          end
        end
      end

      ST_SPLIT: begin
        if (div_rsp.done) begin
          int_nxt   = div_rsp.quo;
          frac_nxt  = div_rsp.rem[FRAC_W-1:0];
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = raw_r;
          out_step_nxt  = k_r;
          out_val_nxt   = trial_r;
          out_int_nxt   = int_r;
          out_frac_nxt  = frac_r;
          out_fw_nxt    = FW_TAB[k_r];
          out_unit_nxt  = UNIT_TAB[k_r];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      raw_r       <= raw_nxt;
      trial_r     <= trial_nxt;
      int_r       <= int_nxt;
      frac_r      <= frac_nxt;
      out_raw_r   <= out_raw_nxt;
      out_step_r  <= out_step_nxt;
      out_val_r   <= out_val_nxt;
      out_int_r   <= out_int_nxt;
      out_frac_r  <= out_frac_nxt;
      out_fw_r    <= out_fw_nxt;
      out_unit_r  <= out_unit_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_raw_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_unit_r, out_fw_r, out_frac_r,
                       out_int_r, out_val_r, out_step_r};

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again while an item is in work");

  a_raw_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_raw_r) |->
      (out_step_r == '0 && out_fw_r == FW_NONE && out_unit_r == '0 && out_frac_r == '0))
    else $error("raw result carries a step, unit or fraction");

  a_scaled_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_raw_r) |->
      (out_step_r != '0 && out_frac_r < SPLIT_TWO_DEN))
    else $error("scaled result without a step or with a bad fraction");
`endif

endmodule

`default_nettype wire
